FILE: rtl/pmzt_pkg.sv
// ----------------------------------------------------------------------------
// Process memory zone table package
// Shared widths, constants and payload types of the zone table and its RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package pmzt_pkg;

	localparam int MAX_ZONES = 16;
	localparam int IDX_W     = $clog2(MAX_ZONES);
	localparam int CNT_W     = $clog2(MAX_ZONES + 1);

	localparam int PID_W  = 16;
	localparam int BYTE_W = 23;

	localparam logic [BYTE_W-1:0] TOTAL_MEMORY_RESET = BYTE_W'(3 * 1024 * 1024);
	localparam logic [BYTE_W-1:0] WORD_BYTES         = BYTE_W'(4);

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_PUSH    = 3'd2;
	localparam logic [2:0] OP_POP     = 3'd3;
	localparam logic [2:0] OP_COMPACT = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [PID_W-1:0]  owner;
		logic [BYTE_W-1:0] base;
		logic [BYTE_W-1:0] length;
		logic [BYTE_W-1:0] stack_bytes;
	} zone_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [PID_W-1:0]  pid;
		logic [BYTE_W-1:0] request_bytes;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] zone_start;
		logic [BYTE_W-1:0] bytes_in_use;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/pmzt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmzt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/process_memory_zone_table.sv
// ----------------------------------------------------------------------------
// Process memory zone table
// First-fit allocator of per-process byte zones with word stack tracking.
// ----------------------------------------------------------------------------
// The block holds one request at a time and walks the zone RAM one entry at a
// time (address in a read state, then registered data in an execute state).
// Unknown ops go straight to the finish state; push, pop and release scan the
// zones, and release also moves each later zone down; allocate scans the zones
// and moves the later zones up; compact runs up to MAX_ZONES-1 bubble passes
// followed by a packing pass. A finished result waits in an output register
// while the next request is taken.
`default_nettype none

module process_memory_zone_table
	import pmzt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [BYTE_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_FIND_RD, S_FIND_EX, S_REL_RD, S_REL_EX,
		S_ALLOC_RD, S_ALLOC_EX, S_TAIL, S_SHIFT_RD, S_SHIFT_EX, S_PUT,
		S_SORT_RD, S_SORT_EX, S_SORT_END, S_PACK_RD, S_PACK_EX, S_FIN
	} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   pass_q;
	logic [BYTE_W-1:0]  total_q;
	logic [BYTE_W-1:0]  total_mem_q;
	logic [BYTE_W:0]    prev_end_q;
	logic [BYTE_W-1:0]  next_q;
	logic [BYTE_W-1:0]  start_q;
	logic [1:0]         status_q;
	zone_t              carry_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	zone_t              wdata;
	logic [IDX_W-1:0]   raddr;
	zone_t              rdata;

	logic [CNT_W-1:0]   i_inc;
	logic [CNT_W-1:0]   i_dec;
	logic [BYTE_W:0]    entry_end;
	logic [BYTE_W+1:0]  gap;
	logic [BYTE_W+1:0]  tail_gap;
	logic [BYTE_W:0]    push_sum;
	logic               fin_free;

	pmzt_ram #(
		.WIDTH($bits(zone_t)),
		.DEPTH(MAX_ZONES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign i_inc     = CNT_W'(i_q + 1'b1);
	assign i_dec     = CNT_W'(i_q - 1'b1);
	assign entry_end = {1'b0, rdata.base} + {1'b0, rdata.length};
	assign gap       = {2'b00, rdata.base} - {1'b0, prev_end_q};
	assign tail_gap  = {2'b00, total_mem_q} - {1'b0, prev_end_q};
	assign push_sum  = {1'b0, rdata.stack_bytes} + {1'b0, WORD_BYTES};
	assign fin_free  = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		we    = 1'b0;
		waddr = i_q[IDX_W-1:0];
		wdata = rdata;
		raddr = i_q[IDX_W-1:0];
		case (state_q)
			S_FIND_EX: begin
				if (rdata.owner == req_q.pid) begin
					if (req_q.op == OP_PUSH && push_sum <= {1'b0, rdata.length}) begin
						we                = 1'b1;
						wdata.stack_bytes = push_sum[BYTE_W-1:0];
					end else if (req_q.op == OP_POP && rdata.stack_bytes != '0) begin
						we                = 1'b1;
						wdata.stack_bytes = rdata.stack_bytes - WORD_BYTES;
					end
				end
			end
			S_REL_EX: begin
				we    = 1'b1;
				waddr = i_dec[IDX_W-1:0];
			end
			S_SHIFT_RD: begin
				raddr = i_dec[IDX_W-1:0];
			end
			S_SHIFT_EX: begin
				we = 1'b1;
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
				wdata = '{owner: req_q.pid, base: start_q,
					length: req_q.request_bytes, stack_bytes: '0};
			end
			S_SORT_EX: begin
				if (i_q != '0) begin
					we    = 1'b1;
					waddr = i_dec[IDX_W-1:0];
					wdata = (carry_q.owner > rdata.owner) ? rdata : carry_q;
				end
			end
			S_SORT_END: begin
				we    = 1'b1;
				waddr = i_dec[IDX_W-1:0];
				wdata = carry_q;
			end
			S_PACK_EX: begin
				we         = 1'b1;
				wdata.base = next_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			total_mem_q <= TOTAL_MEMORY_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				total_mem_q <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready && !(state_q == S_FIN && fin_free)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q    <= req;
						i_q      <= '0;
						start_q  <= '0;
						pass_q   <= '0;
						next_q   <= '0;
						case (req.op)
							OP_ALLOC: begin
								if (count_q >= CNT_W'(MAX_ZONES)) begin
									status_q <= ST_NO_SPACE;
									state_q  <= S_FIN;
								end else if (count_q == '0) begin
									if (req.request_bytes > total_mem_q) begin
										status_q <= ST_NO_SPACE;
										state_q  <= S_FIN;
									end else begin
										status_q <= ST_OK;
										pos_q    <= '0;
										state_q  <= S_PUT;
									end
								end else begin
									status_q <= ST_OK;
									state_q  <= S_ALLOC_RD;
								end
							end
							OP_RELEASE, OP_PUSH, OP_POP: begin
								if (count_q == '0) begin
									status_q <= ST_NOT_FOUND;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_FIND_RD;
								end
							end
							OP_COMPACT: begin
								status_q <= ST_OK;
								if (count_q >= CNT_W'(2)) begin
									state_q <= S_SORT_RD;
								end else if (count_q != '0) begin
									state_q <= S_PACK_RD;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_EX;
				end
				S_FIND_EX: begin
					if (rdata.owner == req_q.pid) begin
						case (req_q.op)
							OP_RELEASE: begin
								total_q <= total_q - rdata.length;
								if (i_inc < count_q) begin
									i_q     <= i_inc;
									state_q <= S_REL_RD;
								end else begin
									count_q <= CNT_W'(count_q - 1'b1);
									state_q <= S_FIN;
								end
							end
							OP_PUSH: begin
								if (push_sum > {1'b0, rdata.length}) begin
									status_q <= ST_NO_SPACE;
								end
								state_q <= S_FIN;
							end
							default: begin
								if (rdata.stack_bytes == '0) begin
									status_q <= ST_EMPTY;
								end
								state_q <= S_FIN;
							end
						endcase
					end else if (i_inc < count_q) begin
						i_q     <= i_inc;
						state_q <= S_FIND_RD;
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end
				end
				S_REL_RD: begin
					state_q <= S_REL_EX;
				end
				S_REL_EX: begin
					if (i_inc < count_q) begin
						i_q     <= i_inc;
						state_q <= S_REL_RD;
					end else begin
						count_q <= CNT_W'(count_q - 1'b1);
						state_q <= S_FIN;
					end
				end
				S_ALLOC_RD: begin
					state_q <= S_ALLOC_EX;
				end
				S_ALLOC_EX: begin
					if (i_q != '0 &&
						$signed(gap) >= $signed({2'b00, req_q.request_bytes})) begin
						pos_q   <= i_q;
						start_q <= prev_end_q[BYTE_W-1:0];
						i_q     <= count_q;
						state_q <= S_SHIFT_RD;
					end else begin
						prev_end_q <= entry_end;
						i_q        <= i_inc;
						state_q    <= (i_inc < count_q) ? S_ALLOC_RD : S_TAIL;
					end
				end
				S_TAIL: begin
					if ($signed(tail_gap) >= $signed({2'b00, req_q.request_bytes})) begin
						pos_q   <= count_q;
						start_q <= prev_end_q[BYTE_W-1:0];
						state_q <= S_PUT;
					end else begin
						status_q <= ST_NO_SPACE;
						state_q  <= S_FIN;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_EX;
				end
				S_SHIFT_EX: begin
					i_q     <= i_dec;
					state_q <= (i_dec > pos_q) ? S_SHIFT_RD : S_PUT;
				end
				S_PUT: begin
					count_q <= CNT_W'(count_q + 1'b1);
					total_q <= total_q + req_q.request_bytes;
					state_q <= S_FIN;
				end
				S_SORT_RD: begin
					state_q <= S_SORT_EX;
				end
				S_SORT_EX: begin
					if (i_q == '0 || !(carry_q.owner > rdata.owner)) begin
						carry_q <= rdata;
					end
					i_q     <= i_inc;
					state_q <= (i_inc < count_q) ? S_SORT_RD : S_SORT_END;
				end
				S_SORT_END: begin
					i_q <= '0;
					if (CNT_W'(pass_q + 2'd2) < count_q) begin
						pass_q  <= CNT_W'(pass_q + 1'b1);
						state_q <= S_SORT_RD;
					end else begin
						state_q <= S_PACK_RD;
					end
				end
				S_PACK_RD: begin
					state_q <= S_PACK_EX;
				end
				S_PACK_EX: begin
					next_q  <= next_q + rdata.length;
					i_q     <= i_inc;
					state_q <= (i_inc < count_q) ? S_PACK_RD : S_FIN;
				end
				S_FIN: begin
					if (fin_free) begin
						rsp_q       <= '{status: status_q, zone_start: start_q,
							bytes_in_use: total_q};
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
